FILE: src/olir_pkg.sv
`default_nettype none

package olir_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ACT_W      = 3;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_APPEND = 3'd3,
        ACT_REMOVE = 3'd4
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    // broadcast to every cell
    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] idx;
    } t_cell_ctl;

    typedef struct packed {
        logic             rd_en;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

FILE: src/ordered_list_insert_remove_top.sv
// Ordered list of up to 64 words held in a row of 64 word cells. Each input word
// carries one action: read, overwrite, insert at a position (later entries move up),
// append, or remove at a position (later entries move down); each gives exactly one
// output word with the value read or removed, a status and the new count. Every cell
// loads itself, its lower or upper neighbor, or the input value in the same cycle, so
// an action of any kind completes at the edge that takes the input word: the result is
// registered at that edge and shows on the output the cycle after. While a result
// waits unaccepted no input is taken; a new input is taken in the same cycle that the
// waiting result is accepted, so with the output always ready one word per cycle goes
// through. Entries come out of reset undefined; only the count and the output valid clear.
`default_nettype none

module ordered_list_insert_remove_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [olir_pkg::ACT_W-1:0]    i_action,
    input  wire logic [olir_pkg::POS_W-1:0]    i_position,
    input  wire logic [olir_pkg::VAL_W-1:0]    i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [olir_pkg::VAL_W-1:0]    o_read_value,
    output logic      [olir_pkg::ST_W-1:0]     o_status,
    output logic      [olir_pkg::POS_W-1:0]    o_count
);

    localparam int N = olir_pkg::CAPACITY;
    localparam int W = olir_pkg::WORD_WIDTH;

    logic                      fire;
    olir_pkg::t_cell_ctl       cell_ctl;
    olir_pkg::t_result         result;
    logic [W-1:0]              words [N];
    logic [W-1:0]              value_in;
    logic [W-1:0]              rd_word;

    logic                      r_out_valid;
    logic [olir_pkg::VAL_W-1:0] r_read_value;
    logic [olir_pkg::ST_W-1:0] r_status;
    logic [olir_pkg::POS_W-1:0] r_count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign value_in   = i_value[W-1:0];

    olir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_action   (i_action),
        .i_position (i_position),
        .o_cell_ctl (cell_ctl),
        .o_result   (result)
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        olir_cell u_cell (
            .i_clk   (i_clk),
            .i_index (olir_pkg::IDX_W'(g)),
            .i_ctl   (cell_ctl),
            .i_value (value_in),
            .i_lower (words[(g == 0) ? g : g - 1]),
            .i_upper (words[(g == N - 1) ? g : g + 1]),
            .o_word  (words[g])
        );
    end

    // one-hot select across the row
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < N; k++) begin
            if (i_position[olir_pkg::IDX_W-1:0] == olir_pkg::IDX_W'(k)) begin
                rd_word = rd_word | words[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_value <= result.rd_en ? olir_pkg::VAL_W'(rd_word) : '0;
            r_status     <= result.status;
            r_count      <= olir_pkg::POS_W'(result.count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count;

endmodule

`default_nettype wire

FILE: src/olir_cell.sv
`default_nettype none

module olir_cell (
    input  wire logic                                i_clk,
    input  wire logic [olir_pkg::IDX_W-1:0]          i_index,
    input  wire olir_pkg::t_cell_ctl                 i_ctl,
    input  wire logic [olir_pkg::WORD_WIDTH-1:0]     i_value,
    input  wire logic [olir_pkg::WORD_WIDTH-1:0]     i_lower,
    input  wire logic [olir_pkg::WORD_WIDTH-1:0]     i_upper,
    output logic      [olir_pkg::WORD_WIDTH-1:0]     o_word
);

    logic [olir_pkg::WORD_WIDTH-1:0] r_word;
    logic [olir_pkg::WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.mode)
            olir_pkg::MODE_HOLD: begin
                n_word = r_word;
            end
            olir_pkg::MODE_WRITE: begin
                if (i_index == i_ctl.idx) begin
                    n_word = i_value;
                end
            end
            olir_pkg::MODE_INSERT: begin
                if (i_index == i_ctl.idx) begin
                    n_word = i_value;
                end else if (i_index > i_ctl.idx) begin
                    n_word = i_lower;
                end
            end
            olir_pkg::MODE_REMOVE: begin
                if (i_index >= i_ctl.idx) begin
                    n_word = i_upper;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: src/olir_ctrl.sv
`default_nettype none

module olir_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [olir_pkg::ACT_W-1:0]    i_action,
    input  wire logic [olir_pkg::POS_W-1:0]    i_position,
    output olir_pkg::t_cell_ctl                o_cell_ctl,
    output olir_pkg::t_result                  o_result
);

    logic [olir_pkg::CNT_W-1:0] r_count;
    logic [olir_pkg::CNT_W-1:0] n_count;
    logic                       is_empty;
    logic                       is_full;
    logic                       pos_ge_cnt;
    logic                       pos_gt_cnt;
    olir_pkg::t_cell_ctl        ctl;

    assign is_empty   = (r_count == '0);
    assign is_full    = (32'(r_count) >= olir_pkg::CAPACITY);
    assign pos_ge_cnt = (32'(i_position) >= 32'(r_count));
    assign pos_gt_cnt = (32'(i_position) > 32'(r_count));

    always_comb begin
        ctl.mode = olir_pkg::MODE_HOLD;
        ctl.idx  = i_position[olir_pkg::IDX_W-1:0];
        n_count  = r_count;
        o_result.rd_en  = 1'b0;
        o_result.status = olir_pkg::ST_OK;
        unique case (i_action)
            olir_pkg::ACT_READ: begin
                if (is_empty) begin
                    o_result.status = olir_pkg::ST_EMPTY;
                end else if (pos_ge_cnt) begin
                    o_result.status = olir_pkg::ST_RANGE;
                end else begin
                    o_result.rd_en = 1'b1;
                end
            end
            olir_pkg::ACT_WRITE: begin
                if (is_empty) begin
                    o_result.status = olir_pkg::ST_EMPTY;
                end else if (pos_ge_cnt) begin
                    o_result.status = olir_pkg::ST_RANGE;
                end else begin
                    ctl.mode = olir_pkg::MODE_WRITE;
                end
            end
            olir_pkg::ACT_REMOVE: begin
                if (is_empty) begin
                    o_result.status = olir_pkg::ST_EMPTY;
                end else if (pos_ge_cnt) begin
                    o_result.status = olir_pkg::ST_RANGE;
                end else begin
                    o_result.rd_en = 1'b1;
                    ctl.mode       = olir_pkg::MODE_REMOVE;
                    n_count        = r_count - 1'b1;
                end
            end
            olir_pkg::ACT_APPEND: begin
                if (is_full) begin
                    o_result.status = olir_pkg::ST_FULL;
                end else begin
                    ctl.mode = olir_pkg::MODE_WRITE;
                    ctl.idx  = r_count[olir_pkg::IDX_W-1:0];
                    n_count  = r_count + 1'b1;
                end
            end
            olir_pkg::ACT_INSERT: begin
                if (is_full) begin
                    o_result.status = olir_pkg::ST_FULL;
                end else if (pos_gt_cnt) begin
                    o_result.status = olir_pkg::ST_RANGE;
                end else begin
                    ctl.mode = olir_pkg::MODE_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            default: begin
                // unused action codes leave the list alone
                ctl.mode = olir_pkg::MODE_HOLD;
            end
        endcase
        o_result.count = n_count;
        o_cell_ctl.idx  = ctl.idx;
        o_cell_ctl.mode = i_fire ? ctl.mode : olir_pkg::MODE_HOLD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: src/olir_checker.sv
`default_nettype none

module olir_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire logic [olir_pkg::ACT_W-1:0]    i_action,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [olir_pkg::VAL_W-1:0]    o_read_value,
    input  wire logic [olir_pkg::ST_W-1:0]     o_status,
    input  wire logic [olir_pkg::POS_W-1:0]    o_count
);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_count) <= olir_pkg::CAPACITY))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == olir_pkg::ST_FULL) |->
            (32'(o_count) == olir_pkg::CAPACITY && o_read_value == '0))
        else $error("full status with wrong count or data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == olir_pkg::ST_EMPTY) |->
            (o_count == '0 && o_read_value == '0))
        else $error("empty status with wrong count or data");

    a_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_action == olir_pkg::ACT_WRITE
            || i_action == olir_pkg::ACT_INSERT || i_action == olir_pkg::ACT_APPEND))
            |=> (o_out_valid && o_read_value == '0))
        else $error("data on a write type action");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_value) && $stable(o_status) && $stable(o_count)))
        else $error("output word changed while stalled");

endmodule

bind ordered_list_insert_remove_top olir_checker u_olir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_count      (o_count)
);

`default_nettype wire

FILE: sim/ordered_list_insert_remove_top_tb.sv
`timescale 1ns / 1ps

module ordered_list_insert_remove_top_tb;

    localparam int CAPACITY = olir_pkg::CAPACITY;
    localparam int ACT_W    = olir_pkg::ACT_W;
    localparam int POS_W    = olir_pkg::POS_W;
    localparam int VAL_W    = olir_pkg::VAL_W;
    localparam int ST_W     = olir_pkg::ST_W;

    localparam int ITEM_TARGET    = 1100;
    localparam int ROUND_LEN      = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRINT_LIMIT    = 50;
    localparam int POS_MAX        = 2**POS_W - 1;

    localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = ACT_W'(olir_pkg::ACT_REMOVE + 1);
    localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = '1;

    typedef enum int {
        MIX_FILL  = 0,
        MIX_DRAIN = 1,
        MIX_EVEN  = 2
    } t_mix;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_list_request;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] count;
    } t_list_outcome;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             in_valid    = 1'b0;
    logic [ACT_W-1:0] in_action   = '0;
    logic [POS_W-1:0] in_position = '0;
    logic [VAL_W-1:0] in_value    = '0;
    logic             out_ready   = 1'b0;

    wire              o_in_ready;
    wire              o_out_valid;
    wire [VAL_W-1:0]  o_read_value;
    wire [ST_W-1:0]   o_status;
    wire [POS_W-1:0]  o_count;

    t_list_request request_queue[$];
    t_list_outcome outcome_fifo[$];

    // shadow of the list contents
    logic [VAL_W-1:0] list_words[CAPACITY];
    int               list_len = 0;

    int gen_len     = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int send_burst  = 0;
    int recv_gap    = 0;
    int recv_burst  = 0;

    t_list_request next_req;
    t_list_outcome want;

    ordered_list_insert_remove_top u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (in_action),
        .i_position   (in_position),
        .i_value      (in_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_list_outcome apply_list_action(
        input logic [ACT_W-1:0] act,
        input logic [POS_W-1:0] pos,
        input logic [VAL_W-1:0] val
    );
        t_list_outcome res;
        int            idx;
        res.read_value = '0;
        res.status     = olir_pkg::ST_OK;
        case (act)
            olir_pkg::ACT_READ, olir_pkg::ACT_WRITE, olir_pkg::ACT_REMOVE: begin
                if (list_len == 0) begin
                    res.status = olir_pkg::ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    res.status = olir_pkg::ST_RANGE;
                end else if (act == olir_pkg::ACT_READ) begin
                    res.read_value = list_words[pos];
                end else if (act == olir_pkg::ACT_WRITE) begin
                    list_words[pos] = val;
                end else begin
                    res.read_value = list_words[pos];
                    for (idx = pos; idx + 1 < list_len; idx++) begin
                        list_words[idx] = list_words[idx + 1];
                    end
                    list_len--;
                end
            end
            olir_pkg::ACT_INSERT, olir_pkg::ACT_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = olir_pkg::ST_FULL;
                end else if (act == olir_pkg::ACT_APPEND) begin
                    list_words[list_len] = val;
                    list_len++;
                end else if (int'(pos) > list_len) begin
                    res.status = olir_pkg::ST_RANGE;
                end else begin
                    for (idx = list_len; idx > pos; idx--) begin
                        list_words[idx] = list_words[idx - 1];
                    end
                    list_words[pos] = val;
                    list_len++;
                end
            end
            default: begin
            end
        endcase
        res.count = POS_W'(list_len);
        return res;
    endfunction

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int pick_gap(ref int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // limit is the first position out of range
    function automatic int pick_position(input int limit);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, POS_MAX);
        if (r == 1) return (limit > POS_MAX) ? POS_MAX : limit;
        if (r == 2) return 0;
        if (limit == 0) return 0;
        if (r == 3) return limit - 1;
        return $urandom_range(0, limit - 1);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic add_item(
        input logic [ACT_W-1:0] act,
        input int               pos,
        input logic [VAL_W-1:0] val
    );
        t_list_request req;
        req.action   = act;
        req.position = POS_W'(pos);
        req.value    = val;
        request_queue.insert(request_queue.size(), req);
        // count only, contents do not steer the stimulus
        case (act)
            olir_pkg::ACT_INSERT: if (gen_len < CAPACITY && pos <= gen_len) gen_len++;
            olir_pkg::ACT_APPEND: if (gen_len < CAPACITY) gen_len++;
            olir_pkg::ACT_REMOVE: if (gen_len > 0 && pos < gen_len) gen_len--;
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(
        input string            what,
        input logic [VAL_W-1:0] got,
        input logic [VAL_W-1:0] expected
    );
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, expected);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                outcome_fifo.insert(outcome_fifo.size(),
                    apply_list_action(in_action, in_position, in_value));
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    next_req = request_queue.pop_front();
                    in_valid    <= 1'b1;
                    in_action   <= next_req.action;
                    in_position <= next_req.position;
                    in_value    <= next_req.value;
                    send_gap = pick_gap(send_burst);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (outcome_fifo.size() == 0) begin
                    report_mismatch("unexpected word", o_read_value, '0);
                end else begin
                    want = outcome_fifo.pop_front();
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", o_read_value, want.read_value);
                    if (o_status !== want.status)
                        report_mismatch("status", VAL_W'(o_status), VAL_W'(want.status));
                    if (o_count !== want.count)
                        report_mismatch("count", VAL_W'(o_count), VAL_W'(want.count));
                end
                recv_gap = pick_gap(recv_burst);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int   random_left;
        int   round_idx;
        int   k;
        int   r;
        int   pos;
        t_mix mix;
        logic [ACT_W-1:0] act;
        int   thr[3][5];

        // cumulative weights: read, overwrite, insert, append, remove
        thr[MIX_FILL]  = '{10, 18, 58, 93, 98};
        thr[MIX_DRAIN] = '{12, 22, 27, 32, 97};
        thr[MIX_EVEN]  = '{19, 38, 57, 76, 95};

        // empty list
        add_item(olir_pkg::ACT_READ,   0, '0);
        add_item(olir_pkg::ACT_WRITE,  0, '1);
        add_item(olir_pkg::ACT_REMOVE, 0, '0);
        add_item(olir_pkg::ACT_INSERT, 1, 32'h1111_1111);
        // insert into empty list, append, insert at end and in the middle
        add_item(olir_pkg::ACT_INSERT, 0, '1);
        add_item(olir_pkg::ACT_APPEND, POS_MAX, '0);
        add_item(olir_pkg::ACT_INSERT, 2, 32'hA5A5_A5A5);
        add_item(olir_pkg::ACT_INSERT, 1, 32'h5A5A_5A5A);
        add_item(olir_pkg::ACT_READ,   3, '0);
        add_item(olir_pkg::ACT_READ,   4, '0);
        add_item(olir_pkg::ACT_READ,   POS_MAX, '0);
        add_item(olir_pkg::ACT_WRITE,  2, 32'h1234_5678);
        add_item(olir_pkg::ACT_WRITE,  4, 32'hDEAD_BEEF);
        add_item(olir_pkg::ACT_INSERT, 6, 32'h0F0F_0F0F);
        add_item(olir_pkg::ACT_REMOVE, 4, '0);
        add_item(olir_pkg::ACT_REMOVE, 1, '0);
        add_item(olir_pkg::ACT_READ,   1, '0);
        // unused action codes
        add_item(ACT_UNUSED_FIRST, POS_MAX, '1);
        add_item(ACT_W'(ACT_UNUSED_FIRST + 1), 1, 32'h8000_0001);
        add_item(ACT_UNUSED_LAST, 0, '0);
        // remove the last entry, then drain to empty
        add_item(olir_pkg::ACT_REMOVE, 2, '0);
        add_item(olir_pkg::ACT_REMOVE, 0, '0);
        add_item(olir_pkg::ACT_REMOVE, 0, '0);
        add_item(olir_pkg::ACT_READ,   0, '0);

        random_left = ITEM_TARGET - request_queue.size();
        round_idx   = 0;
        while (random_left > 0) begin
            mix = t_mix'(round_idx % 3);
            for (k = 0; k < ROUND_LEN && random_left > 0; k++) begin
                r = $urandom_range(0, 99);
                if (r < thr[mix][0]) act = olir_pkg::ACT_READ;
                else if (r < thr[mix][1]) act = olir_pkg::ACT_WRITE;
                else if (r < thr[mix][2]) act = olir_pkg::ACT_INSERT;
                else if (r < thr[mix][3]) act = olir_pkg::ACT_APPEND;
                else if (r < thr[mix][4]) act = olir_pkg::ACT_REMOVE;
                else act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
                if (act == olir_pkg::ACT_INSERT) pos = pick_position(gen_len + 1);
                else if (act == olir_pkg::ACT_APPEND || act > olir_pkg::ACT_REMOVE)
                    pos = $urandom_range(0, POS_MAX);
                else pos = pick_position(gen_len);
                if (act <= olir_pkg::ACT_REMOVE) random_left--;
                add_item(act, pos, pick_value());
            end
            round_idx++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so that every update of the edge has landed
        while (request_queue.size() != 0 || in_valid || outcome_fifo.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/olir_pkg.sv
src/olir_cell.sv
src/olir_ctrl.sv
src/ordered_list_insert_remove_top.sv
src/olir_checker.sv
sim/ordered_list_insert_remove_top_tb.sv
